// ----- design/shh_pkg.sv -----
// Shared types and constants of the strip hit histogrammer.
package shh_pkg;

    localparam int PEAK_BIN_WIDTH  = 10;
    // floor(p / 10) == (p * PEAK_RECIP) >> PEAK_SHIFT for every p below 2^15
    localparam int PEAK_RECIP      = 52429;
    localparam int PEAK_SHIFT      = 19;

    typedef enum logic [1:0] {
        OP_HIT  = 2'd0,
        OP_EOE  = 2'd1,
        OP_READ = 2'd2,
        OP_RSVD = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_PEAK = 2'd0,
        KIND_OCC  = 2'd1,
        KIND_X    = 2'd2,
        KIND_Y    = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_HIT_PEAK,
        S_HIT_BIN,
        S_HIT_RD,
        S_HIT_WR,
        S_EOE_RD,
        S_EOE_WR,
        S_RD_RD,
        S_RD_WAIT,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic clr_wr;
        logic capture;
        logic hit_peak;
        logic hit_bin;
        logic hit_rd;
        logic hit_wr;
        logic eoe_start;
        logic eoe_rd;
        logic eoe_wr;
        logic rd_rd;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        t_op  op;
        logic req_bad;
        logic eoe_last;
        logic out_free;
    } t_status;

endpackage

// ----- design/shh_ctrl.sv -----
// Sequencer of the strip hit histogrammer.
module shh_ctrl import shh_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.req_bad) begin
                    n_state = S_RESULT;
                end else begin
                    case (i_status.op)
                        OP_HIT:  n_state = S_HIT_PEAK;
                        OP_EOE: begin
                            o_cmd.eoe_start = 1'b1;
                            n_state         = S_EOE_RD;
                        end
                        OP_READ: n_state = S_RD_RD;
                        default: n_state = S_RESULT;
                    endcase
                end
            end
            S_HIT_PEAK: begin
                o_cmd.hit_peak = 1'b1;
                n_state        = S_HIT_BIN;
            end
            S_HIT_BIN: begin
                o_cmd.hit_bin = 1'b1;
                n_state       = S_HIT_RD;
            end
            S_HIT_RD: begin
                o_cmd.hit_rd = 1'b1;
                n_state      = S_HIT_WR;
            end
            S_HIT_WR: begin
                o_cmd.hit_wr = 1'b1;
                n_state      = S_IDLE;
            end
            S_EOE_RD: begin
                o_cmd.eoe_rd = 1'b1;
                n_state      = S_EOE_WR;
            end
            S_EOE_WR: begin
                o_cmd.eoe_wr = 1'b1;
                n_state      = i_status.eoe_last ? S_IDLE : S_EOE_RD;
            end
            S_RD_RD: begin
                o_cmd.rd_rd = 1'b1;
                n_state     = S_RD_WAIT;
            end
            S_RD_WAIT: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- design/shh_datapath.sv -----
// Histogram memories, binning arithmetic and result register.
module shh_datapath import shh_pkg::*; #(
    parameter int PEAK_BINS          = 1000,
    parameter int OCCUPANCY_BINS     = 100,
    parameter int X_BINS             = 768,
    parameter int Y_BINS             = 640,
    parameter int DETECTORS          = 5,
    parameter int MAX_HITS_PER_EVENT = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic [1:0]         i_operation,
    input  logic signed [15:0] i_sample_a,
    input  logic signed [15:0] i_sample_b,
    input  logic signed [15:0] i_sample_c,
    input  logic signed [15:0] i_sample_d,
    input  logic signed [15:0] i_sample_e,
    input  logic signed [15:0] i_sample_f,
    input  logic [2:0]         i_detector,
    input  logic               i_plane,
    input  logic [10:0]        i_strip,
    input  logic [1:0]         i_histogram_kind,
    input  logic [9:0]         i_bin_index,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic [31:0]        o_bin_count,
    output logic               o_request_error
);

    localparam int DW  = (DETECTORS > 1) ? $clog2(DETECTORS) : 1;
    localparam int SW  = DW + 1;
    localparam int PW  = $clog2(PEAK_BINS + 1);
    localparam int OW  = $clog2(OCCUPANCY_BINS + 1);
    localparam int XW  = $clog2(X_BINS + 1);
    localparam int YW  = $clog2(Y_BINS + 1);
    localparam int EW  = $clog2(MAX_HITS_PER_EVENT);
    localparam int PA  = SW + PW;
    localparam int OA  = SW + OW;
    localparam int XA  = DW + XW;
    localparam int YA  = DW + YW;
    localparam int M1  = (PA > OA) ? PA : OA;
    localparam int M2  = (XA > YA) ? XA : YA;
    localparam int CLW = (M1 > M2) ? M1 : M2;

    logic [31:0] r_peak_mem [2**PA];
    logic [31:0] r_occ_mem  [2**OA];
    logic [31:0] r_x_mem    [2**XA];
    logic [31:0] r_y_mem    [2**YA];
    logic [31:0] r_peak_q, r_occ_q, r_x_q, r_y_q;

    logic [EW-1:0] r_evc [2**SW];

    logic [CLW-1:0] r_clr;
    logic [SW-1:0]  r_eset;

    logic [1:0]         r_op;
    logic signed [15:0] r_smp [6];
    logic [2:0]         r_det;
    logic               r_plane;
    logic [10:0]        r_strip;
    logic [1:0]         r_kind;
    logic [9:0]         r_idx;

    logic [14:0]   r_peak;
    logic [PW-1:0] r_peak_bin;

    logic        r_out_valid;
    logic [31:0] r_bin_count;
    logic        r_req_err;

    logic signed [15:0] m01, m23, m45, m03, mall;
    logic [30:0]        prod;
    logic [12:0]        q13;
    logic [11:0]        sbin;
    logic [XW-1:0]      xbin;
    logic [YW-1:0]      ybin;
    logic [SW-1:0]      hset;
    logic [EW-1:0]      ecnt;
    logic [OW-1:0]      obin;
    logic               bad_det, bad_idx;
    logic [PA-1:0]      peak_addr;
    logic [OA-1:0]      occ_addr;
    logic [XA-1:0]      x_addr;
    logic [YA-1:0]      y_addr;
    logic [31:0]        sel_q;
    logic               mem_rd;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (&v) ? v : v + 32'd1;
    endfunction

    // capture of the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_operation;
            r_smp[0] <= i_sample_a;
            r_smp[1] <= i_sample_b;
            r_smp[2] <= i_sample_c;
            r_smp[3] <= i_sample_d;
            r_smp[4] <= i_sample_e;
            r_smp[5] <= i_sample_f;
            r_det    <= i_detector;
            r_plane  <= i_plane;
            r_strip  <= i_strip;
            r_kind   <= i_histogram_kind;
            r_idx    <= i_bin_index;
        end
    end

    // peak, floored at zero
    assign m01  = (r_smp[0] > r_smp[1]) ? r_smp[0] : r_smp[1];
    assign m23  = (r_smp[2] > r_smp[3]) ? r_smp[2] : r_smp[3];
    assign m45  = (r_smp[4] > r_smp[5]) ? r_smp[4] : r_smp[5];
    assign m03  = (m01 > m23) ? m01 : m23;
    assign mall = (m03 > m45) ? m03 : m45;

    assign prod = 31'(r_peak) * 31'(PEAK_RECIP);
    assign q13  = {1'b0, prod[PEAK_SHIFT +: 12]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.hit_peak) begin
            r_peak <= mall[15] ? 15'd0 : mall[14:0];
        end
        if (i_cmd.hit_bin) begin
            r_peak_bin <= (q13 >= 13'(PEAK_BINS)) ? PW'(PEAK_BINS) : PW'(q13);
        end
    end

    // strip and occupancy binning
    assign sbin = {2'b00, r_strip[10:1]};
    assign xbin = (sbin >= 12'(X_BINS)) ? XW'(X_BINS) : XW'(sbin);
    assign ybin = (sbin >= 12'(Y_BINS)) ? YW'(Y_BINS) : YW'(sbin);
    assign hset = {r_det[DW-1:0], r_plane};
    assign ecnt = r_evc[r_eset];
    assign obin = (32'(ecnt) >= 32'(OCCUPANCY_BINS)) ? OW'(OCCUPANCY_BINS) : OW'(ecnt);

    // request checks
    assign bad_det = 32'(r_det) >= 32'(DETECTORS);
    always_comb begin
        case (t_kind'(r_kind))
            KIND_PEAK: bad_idx = 32'(r_idx) > 32'(PEAK_BINS);
            KIND_OCC:  bad_idx = 32'(r_idx) > 32'(OCCUPANCY_BINS);
            KIND_X:    bad_idx = 32'(r_idx) > 32'(X_BINS);
            KIND_Y:    bad_idx = 32'(r_idx) > 32'(Y_BINS);
            default:   bad_idx = 1'b1;
        endcase
    end

    // addresses: hit and end-of-event binning, or read request
    always_comb begin
        if (i_cmd.rd_rd) begin
            peak_addr = {hset, PW'(r_idx)};
            occ_addr  = {hset, OW'(r_idx)};
            x_addr    = {r_det[DW-1:0], XW'(r_idx)};
            y_addr    = {r_det[DW-1:0], YW'(r_idx)};
        end else begin
            peak_addr = {hset, r_peak_bin};
            occ_addr  = {r_eset, obin};
            x_addr    = {r_det[DW-1:0], xbin};
            y_addr    = {r_det[DW-1:0], ybin};
        end
    end

    // read data is held until the next read step
    assign mem_rd = i_cmd.rd_rd || i_cmd.hit_rd || i_cmd.eoe_rd;

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_peak_mem[PA'(r_clr)] <= '0;
        end else if (i_cmd.hit_wr) begin
            r_peak_mem[peak_addr] <= sat_inc(r_peak_q);
        end
        if (mem_rd) begin
            r_peak_q <= r_peak_mem[peak_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_occ_mem[OA'(r_clr)] <= '0;
        end else if (i_cmd.eoe_wr) begin
            r_occ_mem[occ_addr] <= sat_inc(r_occ_q);
        end
        if (mem_rd) begin
            r_occ_q <= r_occ_mem[occ_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_x_mem[XA'(r_clr)] <= '0;
        end else if (i_cmd.hit_wr && !r_plane) begin
            r_x_mem[x_addr] <= sat_inc(r_x_q);
        end
        if (mem_rd) begin
            r_x_q <= r_x_mem[x_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_y_mem[YA'(r_clr)] <= '0;
        end else if (i_cmd.hit_wr && r_plane) begin
            r_y_mem[y_addr] <= sat_inc(r_y_q);
        end
        if (mem_rd) begin
            r_y_q <= r_y_mem[y_addr];
        end
    end

    // per-event counts, clear sweep and event walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 2**SW; i++) begin
                r_evc[i] <= '0;
            end
            r_clr  <= '0;
            r_eset <= '0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.eoe_start) begin
                r_eset <= '0;
            end else if (i_cmd.eoe_wr) begin
                r_evc[r_eset] <= '0;
                r_eset        <= r_eset + 1'b1;
            end
            if (i_cmd.hit_wr && (32'(r_evc[hset]) < 32'(MAX_HITS_PER_EVENT - 1))) begin
                r_evc[hset] <= r_evc[hset] + 1'b1;
            end
        end
    end

    // result register
    always_comb begin
        case (t_kind'(r_kind))
            KIND_PEAK: sel_q = r_peak_q;
            KIND_OCC:  sel_q = r_occ_q;
            KIND_X:    sel_q = r_x_q;
            KIND_Y:    sel_q = r_y_q;
            default:   sel_q = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_req_err   <= o_status.req_bad || (t_op'(r_op) != OP_READ);
            r_bin_count <= (o_status.req_bad || (t_op'(r_op) != OP_READ)) ? 32'd0 : sel_q;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_bin_count     = r_bin_count;
    assign o_request_error = r_req_err;

    assign o_status.clr_done = &r_clr;
    assign o_status.op       = t_op'(r_op);
    assign o_status.req_bad  = (t_op'(r_op) == OP_RSVD)
                             || ((t_op'(r_op) == OP_HIT) && bad_det)
                             || ((t_op'(r_op) == OP_READ) && (bad_det || bad_idx));
    assign o_status.eoe_last = r_eset == SW'(2 * DETECTORS - 1);
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> r_out_valid)
        else $error("result register not loaded");
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || !i_out_stall))
        else $error("result overwritten while stalled");
    a_no_update_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_wr |-> !(i_cmd.hit_wr || i_cmd.eoe_wr || i_cmd.capture))
        else $error("histogram update during clear sweep");

endmodule

// ----- design/strip_hit_histogrammer_unit.sv -----
// Top level of the strip hit histogrammer.
// After reset the block sweeps all four histogram memories to zero, one address
// per cycle over 2**CLW addresses (16384 with the default sizes), with o_in_stall
// high; afterwards one item is processed at a time. A hit passes capture, decode,
// peak search, divide-by-10 binning, memory read and saturating write back before
// the block is ready again. An end-of-event item walks the per-event counters, a
// read and a write on the occupancy memory port per detector/plane pair. A read
// passes capture, decode, memory read and a wait step to its result, a refused
// request capture and decode. Results sit in an output register, so a stalled
// consumer only holds the block when a further result must be produced.
module strip_hit_histogrammer_unit import shh_pkg::*; #(
    parameter int PEAK_BINS          = 1000,
    parameter int OCCUPANCY_BINS     = 100,
    parameter int X_BINS             = 768,
    parameter int Y_BINS             = 640,
    parameter int DETECTORS          = 5,
    parameter int MAX_HITS_PER_EVENT = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_operation,
    input  logic signed [15:0] i_sample_a,
    input  logic signed [15:0] i_sample_b,
    input  logic signed [15:0] i_sample_c,
    input  logic signed [15:0] i_sample_d,
    input  logic signed [15:0] i_sample_e,
    input  logic signed [15:0] i_sample_f,
    input  logic [2:0]         i_detector,
    input  logic               i_plane,
    input  logic [10:0]        i_strip,
    input  logic [1:0]         i_histogram_kind,
    input  logic [9:0]         i_bin_index,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [31:0]        o_bin_count,
    output logic               o_request_error
);

    t_cmd    cmd;
    t_status status;

    // sequencer: owns the item flow
    shh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // memories, binning and the result register
    shh_datapath #(
        .PEAK_BINS          (PEAK_BINS),
        .OCCUPANCY_BINS     (OCCUPANCY_BINS),
        .X_BINS             (X_BINS),
        .Y_BINS             (Y_BINS),
        .DETECTORS          (DETECTORS),
        .MAX_HITS_PER_EVENT (MAX_HITS_PER_EVENT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_operation      (i_operation),
        .i_sample_a       (i_sample_a),
        .i_sample_b       (i_sample_b),
        .i_sample_c       (i_sample_c),
        .i_sample_d       (i_sample_d),
        .i_sample_e       (i_sample_e),
        .i_sample_f       (i_sample_f),
        .i_detector       (i_detector),
        .i_plane          (i_plane),
        .i_strip          (i_strip),
        .i_histogram_kind (i_histogram_kind),
        .i_bin_index      (i_bin_index),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_bin_count      (o_bin_count),
        .o_request_error  (o_request_error)
    );

endmodule
